FILE: hw/rtl/itoa_pkg.sv
// Shared types, constants and the BCD shift step for the signed decimal text unit.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int VALUE_W       = 32;
   localparam int CHAR_W        = 8;
   localparam int DIGIT_W       = 4;
   localparam int NUM_DIGITS    = 10;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int DIGIT_IDX_W   = $clog2(NUM_DIGITS);
   localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_type;

   // Classified number waiting for conversion
   typedef struct packed {
      logic               negative;
      logic [VALUE_W-1:0] magnitude;
   } item_type;

   // Converted number handed to the character stage
   typedef struct packed {
      logic    negative;
      bcd_type digits;
   } text_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_RUN,
      CONV_DONE
   } conv_state_type;

   // One shift-add-3 step: fix up digits of five or more, then shift a bit in
   function automatic bcd_type dabble_bit(bcd_type bcd, logic bit_in);
      bcd_type          adj;
      logic [BCD_W-1:0] flat;
      adj = bcd;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (adj[i] >= 4'd5) begin
            adj[i] = adj[i] + 4'd3;
         end
      end
      flat = adj;
      return bcd_type'({flat[BCD_W-2:0], bit_in});
   endfunction

endpackage

FILE: hw/rtl/itoa_front.sv
// Front stage: takes request beats, splits off the sign and forms the magnitude.
// Depends on itoa_pkg; feeds itoa_queue.
`timescale 1ns / 1ps

module itoa_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [itoa_pkg::VALUE_W-1:0] req_tdata,  // [31:0] value
   output logic                                push,
   output itoa_pkg::item_type                  push_item,
   input  logic                                full
);
   import itoa_pkg::*;

   logic [VALUE_W-1:0] raw;

   // Accept whenever the queue has room
   assign req_tready = !full;
   assign push       = req_tvalid && !full;

   // Widen-free negate: the most negative value maps onto itself as unsigned
   assign raw                = req_tdata;
   assign push_item.negative = raw[VALUE_W-1];
   assign push_item.magnitude = raw[VALUE_W-1] ? (~raw + {{(VALUE_W-1){1'b0}}, 1'b1}) : raw;

endmodule

FILE: hw/rtl/itoa_queue.sv
// Short FIFO of classified numbers between the front stage and the converter.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_queue #(
   parameter int DEPTH = itoa_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  itoa_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output itoa_pkg::item_type head_item,
   output logic               empty
);
   import itoa_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/itoa_conv.sv
// Converter: turns a binary magnitude into ten BCD digits, four bits per cycle.
// Depends on itoa_pkg; pops itoa_queue and hands results to itoa_emit.
`timescale 1ns / 1ps

module itoa_conv (
   input  logic               clock,
   input  logic               reset,
   input  itoa_pkg::item_type head_item,
   input  logic               empty,
   output logic               pop,
   output itoa_pkg::text_type text,
   output logic               text_valid,
   input  logic               text_take
);
   import itoa_pkg::*;

   conv_state_type        state_ff, state_in;
   logic                  negative_ff, negative_in;
   logic [VALUE_W-1:0]    shift_ff, shift_in;
   bcd_type               bcd_ff, bcd_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   bcd_type               bcd_step;
   logic                  load;

   assign text_valid    = (state_ff == CONV_DONE);
   assign text.negative = negative_ff;
   assign text.digits   = bcd_ff;

   // Shift the top bits of the magnitude into the digit register
   always_comb begin
      bcd_step = bcd_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         bcd_step = dabble_bit(bcd_step, shift_ff[VALUE_W-1-k]);
      end
   end

   // Sequence load, run and hand-off
   always_comb begin
      state_in    = state_ff;
      negative_in = negative_ff;
      shift_in    = shift_ff;
      bcd_in      = bcd_ff;
      step_in     = step_ff;
      load        = 1'b0;
      case (state_ff)
         CONV_IDLE: begin
            if (!empty) begin
               load = 1'b1;
            end
         end
         CONV_RUN: begin
            bcd_in   = bcd_step;
            shift_in = shift_ff << BITS_PER_STEP;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_CNT_W'(CONV_STEPS - 1)) begin
               state_in = CONV_DONE;
            end
         end
         CONV_DONE: begin
            if (text_take) begin
               if (!empty) begin
                  load = 1'b1;
               end else begin
                  state_in = CONV_IDLE;
               end
            end
         end
         default: begin
            state_in = CONV_IDLE;
         end
      endcase
      if (load) begin
         state_in    = CONV_RUN;
         negative_in = head_item.negative;
         shift_in    = head_item.magnitude;
         bcd_in      = '0;
         step_in     = '0;
      end
   end

   assign pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      negative_ff <= negative_in;
      shift_ff    <= shift_in;
      bcd_ff      <= bcd_in;
   end

endmodule

FILE: hw/rtl/itoa_emit.sv
// Character stage: sends sign and significant digits, one beat per rsp_tready cycle.
// Depends on itoa_pkg; takes converted numbers from itoa_conv.
`timescale 1ns / 1ps

module itoa_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  itoa_pkg::text_type            text,
   input  logic                          text_valid,
   output logic                          text_take,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [itoa_pkg::CHAR_W-1:0]   rsp_tdata,  // [7:0] character
   output logic                          rsp_tlast   // last
);
   import itoa_pkg::*;

   logic                   active_ff, active_in;
   logic                   sign_ff, sign_in;
   bcd_type                digits_ff, digits_in;
   logic [DIGIT_IDX_W-1:0] pos_ff, pos_in;
   logic [DIGIT_IDX_W-1:0] lead;
   logic                   beat;
   logic                   last_char;

   assign last_char  = !sign_ff && (pos_ff == '0);
   assign beat       = active_ff && rsp_tready;
   assign text_take  = text_valid && (!active_ff || (rsp_tready && last_char));
   assign rsp_tvalid = active_ff;
   assign rsp_tlast  = last_char;
   assign rsp_tdata  = sign_ff ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(digits_ff[pos_ff]));

   // Find the highest nonzero digit; zero keeps the units digit
   always_comb begin
      lead = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (text.digits[i] != '0) begin
            lead = DIGIT_IDX_W'(i);
         end
      end
   end

   // Load a new number or step down one character per beat
   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      digits_in = digits_ff;
      pos_in    = pos_ff;
      if (text_take) begin
         active_in = 1'b1;
         sign_in   = text.negative;
         digits_in = text.digits;
         pos_in    = lead;
      end else if (beat) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (pos_ff == '0) begin
            active_in = 1'b0;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         sign_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         sign_ff   <= sign_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      pos_ff    <= pos_in;
   end

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii_unit.sv
// Signed 32-bit integer to decimal ASCII text, most significant character first.
// A request beat goes through the queue, the converter (four bits per step)
// and a load into the character stage before its first character is sent.
// Numbers give N = 1..11 characters; the character stage sends one beat per
// cycle when rsp_tready is high, while the next number converts.
// Reset clears the queue, converter and character stage; no clearing pass.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit #(
   parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [itoa_pkg::VALUE_W-1:0] req_tdata,  // [31:0] value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [itoa_pkg::CHAR_W-1:0]         rsp_tdata,  // [7:0] character
   output logic                                rsp_tlast   // last
);
   import itoa_pkg::*;

   logic     push, full, pop, empty;
   item_type push_item, head_item;
   text_type text;
   logic     text_valid, text_take;

   // Classify incoming numbers
   itoa_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_item  (push_item),
      .full       (full)
   );

   // Decouple front and back
   itoa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .head_item (head_item),
      .empty     (empty)
   );

   // Convert magnitude to BCD
   itoa_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .empty      (empty),
      .pop        (pop),
      .text       (text),
      .text_valid (text_valid),
      .text_take  (text_take)
   );

   // Send characters
   itoa_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .text       (text),
      .text_valid (text_valid),
      .text_take  (text_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
